>>> src/b64d_pkg.sv
// Shared types and character constants for the base64 decoder.
package b64d_pkg;

    localparam logic [7:0] CHAR_PAD        = 8'h3D; // '='
    localparam logic [7:0] CHAR_PLUS       = 8'h2B; // '+'
    localparam logic [7:0] CHAR_SLASH      = 8'h2F; // '/'
    localparam logic [7:0] CHAR_MINUS      = 8'h2D; // '-'
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F; // '_'
    localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0    = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9    = 8'h39;

    localparam logic [5:0] SEXTET_62 = 6'd62;
    localparam logic [5:0] SEXTET_63 = 6'd63;

    // Bytes produced by one character, handed from the group stage to the output stage.
    typedef struct packed {
        logic [23:0] data;   // first byte in [23:16]
        logic [1:0]  count;  // number of result bytes, 1 to 3
        logic        last;   // final byte of the message carries last
        logic        error;  // single error result
    } t_result;

endpackage

>>> src/b64d_sextet_map.sv
// Maps one character code to its sextet value and a validity flag.
module b64d_sextet_map
    import b64d_pkg::*;
(
    input  logic [7:0] i_char,
    input  logic       i_url_safe,
    output logic [5:0] o_sextet,
    output logic       o_ok
);

    logic [7:0] w_off;

    always_comb begin
        w_off    = 8'd0;
        o_sextet = 6'd0;
        o_ok     = 1'b1;
        if (i_char >= CHAR_UPPER_A && i_char <= CHAR_UPPER_Z) begin
            w_off    = i_char - CHAR_UPPER_A;
            o_sextet = w_off[5:0];
        end else if (i_char >= CHAR_LOWER_A && i_char <= CHAR_LOWER_Z) begin
            w_off    = i_char - CHAR_LOWER_A + 8'd26;
            o_sextet = w_off[5:0];
        end else if (i_char >= CHAR_DIGIT_0 && i_char <= CHAR_DIGIT_9) begin
            w_off    = i_char - CHAR_DIGIT_0 + 8'd52;
            o_sextet = w_off[5:0];
        end else if (i_char == CHAR_PLUS) begin
            o_sextet = SEXTET_62;
        end else if (i_char == CHAR_SLASH) begin
            o_sextet = SEXTET_63;
        end else if (i_char == CHAR_PAD) begin
            o_sextet = 6'd0;
        end else if (i_url_safe && i_char == CHAR_MINUS) begin
            o_sextet = SEXTET_62;
        end else if (i_url_safe && i_char == CHAR_UNDERSCORE) begin
            o_sextet = SEXTET_63;
        end else begin
            o_ok = 1'b0;
        end
    end

endmodule

>>> src/b64d_group.sv
// Input register and group assembly: gathers sextets and forms result bundles.
module b64d_group
    import b64d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_url_safe,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_char,
    input  logic       i_in_last,
    input  logic       i_res_ready,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic        r_in_valid;
    logic [7:0]  r_char;
    logic        r_last;
    logic [17:0] r_acc;
    logic [1:0]  r_pos;
    logic        r_third_pad;
    logic        r_sticky;

    logic [17:0] n_acc;
    logic [1:0]  n_pos;
    logic        n_third_pad;
    logic        n_sticky;

    logic [5:0]  w_sx;
    logic        w_ok;
    logic        w_pad;
    logic [2:0]  w_count;
    logic        w_err;
    logic        w_third;
    logic [23:0] w_t;
    logic [1:0]  w_n;
    logic        w_advance;

    b64d_sextet_map u_map (
        .i_char     (r_char),
        .i_url_safe (i_url_safe),
        .o_sextet   (w_sx),
        .o_ok       (w_ok)
    );

    always_comb begin
        w_pad   = (r_char == CHAR_PAD);
        w_count = {1'b0, r_pos} + 3'd1;
        w_err   = r_sticky | ~w_ok;
        w_third = (w_count == 3'd3) ? w_pad : r_third_pad;

        n_acc       = 18'd0;
        n_pos       = 2'd0;
        n_third_pad = 1'b0;
        n_sticky    = 1'b0;
        w_t         = 24'd0;
        w_n         = 2'd0;

        if (!r_last) begin
            if (w_count != 3'd4) begin
                n_acc       = {r_acc[11:0], w_sx};
                n_pos       = w_count[1:0];
                n_third_pad = w_third;
                n_sticky    = w_err;
            end else begin
                w_t      = {r_acc, w_sx};
                n_sticky = w_err;
                w_n      = w_err ? 2'd0 : 2'd3;
            end
        end else if (w_err) begin
            w_n = 2'd1;
        end else begin
            // pad a short final group with zero sextets
            case (w_count)
                3'd1:    w_t = {w_sx, 18'd0};
                3'd2:    w_t = {r_acc[5:0], w_sx, 12'd0};
                3'd3:    w_t = {r_acc[11:0], w_sx, 6'd0};
                default: w_t = {r_acc, w_sx};
            endcase
            case (w_count)
                3'd4:    w_n = 2'd3 - {1'b0, r_third_pad} - {1'b0, w_pad};
                3'd3:    w_n = 2'd2 - {1'b0, w_pad};
                default: w_n = 2'd1;
            endcase
        end
    end

    // an item with no bytes can retire while the output stage is busy
    assign w_advance   = r_in_valid && ((w_n == 2'd0) || i_res_ready);
    assign o_stall     = r_in_valid && !w_advance;
    assign o_res_valid = r_in_valid && (w_n != 2'd0);

    always_comb begin
        o_res.data  = (r_last && w_err) ? 24'd0 : w_t;
        o_res.count = w_n;
        o_res.last  = r_last;
        o_res.error = r_last && w_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_acc       <= 18'd0;
            r_pos       <= 2'd0;
            r_third_pad <= 1'b0;
            r_sticky    <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (w_advance) begin
                r_acc       <= n_acc;
                r_pos       <= n_pos;
                r_third_pad <= n_third_pad;
                r_sticky    <= n_sticky;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_char <= i_in_char;
            r_last <= i_in_last;
        end
    end

endmodule

>>> src/b64d_out_serializer.sv
// Result register: holds one bundle and sends its bytes one transfer at a time.
module b64d_out_serializer
    import b64d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_res_valid,
    input  t_result    i_res,
    output logic       o_res_ready,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic       o_out_error
);

    logic        r_valid;
    t_result     r_res;
    logic [1:0]  r_idx;
    logic        w_take;
    logic        w_final;

    assign w_take      = r_valid && !i_stall;
    assign w_final     = (r_idx == r_res.count - 2'd1);
    assign o_res_ready = !r_valid || (w_take && w_final);
    assign o_valid     = r_valid;

    always_comb begin
        case (r_idx)
            2'd0:    o_out_byte = r_res.data[23:16];
            2'd1:    o_out_byte = r_res.data[15:8];
            default: o_out_byte = r_res.data[7:0];
        endcase
        o_out_last  = r_res.last && w_final;
        o_out_error = r_res.error;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
            r_idx   <= 2'd0;
        end else if (w_take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

>>> src/base64_decoder_top.sv
// An accepted character enters the input register; its result bytes then enter the result
// register. Throughput: one character per cycle unless o_stall holds it; the result register
// sends one byte per cycle unless i_stall holds it, so a group yielding three bytes holds the
// input until its bytes are sent, unless the characters in between yield nothing.
// Reset: synchronous, active low; clears group state, error flag and url-safe mode.
module base64_decoder_top
    import b64d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_char,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic       o_out_error
);

    logic    r_url_safe;
    logic    w_res_valid;
    logic    w_res_ready;
    t_result w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_url_safe <= 1'b0;
        end else if (i_cfg_we) begin
            r_url_safe <= i_cfg_data;
        end
    end

    b64d_group u_group (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_url_safe  (r_url_safe),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_char   (i_in_char),
        .i_in_last   (i_in_last),
        .i_res_ready (w_res_ready),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    b64d_out_serializer u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_res_ready (w_res_ready),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .o_out_error (o_out_error)
    );

endmodule

>>> bench/tb_base64_decoder_top.sv
`timescale 1ns / 1ps
// Self-checking bench for base64_decoder_top: directed table, then random messages.
module tb_base64_decoder_top;
    import b64d_pkg::*;

    localparam int RAND_ITEMS  = 75;
    localparam int PHASE_ITEMS = 20;
    localparam int DRAIN_SLACK = 8;
    localparam int HOLD_AT     = 40;
    localparam int HOLD_CYCLES = 120;
    localparam int DIR_ROWS    = 25;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       error;
    } t_byte_result;

    // One directed character, with an optional hand-written result for its message.
    typedef struct packed {
        logic         mode;
        logic [7:0]   ch;
        logic         last;
        logic         typed;
        t_byte_result res;
    } t_dir_row;

    localparam logic [10:0] FROM_PREDICTOR = '0;
    localparam logic [10:0] ERROR_RESULT   = {1'b1, 8'h00, 1'b1, 1'b1};

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_cfg_we   = 1'b0;
    logic       i_cfg_data = 1'b0;
    logic       i_valid    = 1'b0;
    logic [7:0] i_in_char  = '0;
    logic       i_in_last  = 1'b0;
    logic       i_stall    = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_out_last;
    logic       o_out_error;

    // Predicted decoder state
    logic [17:0] grp_acc       = '0;
    logic [1:0]  grp_pos       = '0;
    logic        grp_third_pad = 1'b0;
    logic        msg_error     = 1'b0;
    logic        url_mode      = 1'b0;

    t_byte_result pending_bytes[$];
    t_dir_row     dir_rows [DIR_ROWS];
    int           mismatch_count = 0;
    int           rx_count       = 0;
    int           rand_items     = 0;
    logic         tx_quiet       = 1'b0;
    logic         rx_quiet       = 1'b0;

    base64_decoder_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_char   (i_in_char),
        .i_in_last   (i_in_last),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .o_out_error (o_out_error)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Returns {valid, sextet} for one character code.
    function automatic logic [6:0] sextet_of(input logic [7:0] ch, input logic url);
        if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) return {1'b1, 6'(ch - CHAR_UPPER_A)};
        if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z)
            return {1'b1, 6'(ch - CHAR_LOWER_A + 8'd26)};
        if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9)
            return {1'b1, 6'(ch - CHAR_DIGIT_0 + 8'd52)};
        if (ch == CHAR_PLUS) return {1'b1, SEXTET_62};
        if (ch == CHAR_SLASH) return {1'b1, SEXTET_63};
        if (ch == CHAR_PAD) return {1'b1, 6'd0};
        if (url && ch == CHAR_MINUS) return {1'b1, SEXTET_62};
        if (url && ch == CHAR_UNDERSCORE) return {1'b1, SEXTET_63};
        return 7'd0;
    endfunction

    function automatic logic [7:0] alphabet_char(input logic [5:0] sx);
        if (sx < 6'd26) return CHAR_UPPER_A + 8'(sx);
        if (sx < 6'd52) return CHAR_LOWER_A + 8'(sx - 6'd26);
        if (sx < 6'd62) return CHAR_DIGIT_0 + 8'(sx - 6'd52);
        if (url_mode && $urandom_range(0, 1) == 1)
            return (sx == SEXTET_62) ? CHAR_MINUS : CHAR_UNDERSCORE;
        return (sx == SEXTET_62) ? CHAR_PLUS : CHAR_SLASH;
    endfunction

    // Append one expected byte at the tail of the queue.
    task automatic queue_byte(input t_byte_result b);
        pending_bytes = {pending_bytes, b};
    endtask

    // Advance the predicted state by one character and queue the bytes it yields.
    task automatic predict_decode(input logic [7:0] ch, input logic last);
        logic [5:0]  sx;
        logic        ok;
        logic        pad;
        logic [23:0] word;
        int          count;
        int          n;
        int          i;
        {ok, sx} = sextet_of(ch, url_mode);
        pad = (ch == CHAR_PAD);
        count = grp_pos + 1;
        if (!ok) msg_error = 1'b1;
        if (count == 3) grp_third_pad = pad;
        word = {grp_acc, sx};
        if (!last && count < 4) begin
            grp_acc = word[17:0];
            grp_pos = count[1:0];
        end else if (!last) begin
            if (!msg_error)
                for (i = 0; i < 3; i++) queue_byte({word[23 - 8 * i -: 8], 2'b00});
        end else if (msg_error) begin
            queue_byte({8'h00, 1'b1, 1'b1});
        end else begin
            // pad a short final group out to four sextets
            word = word << (6 * (4 - count));
            if (count == 4) n = 3 - grp_third_pad - pad;
            else if (count == 3) n = 2 - pad;
            else n = 1;
            for (i = 0; i < n; i++)
                queue_byte({word[23 - 8 * i -: 8], i == n - 1, 1'b0});
        end
        if (last || count == 4) begin
            grp_acc = '0;
            grp_pos = '0;
            grp_third_pad = 1'b0;
        end
        if (last) msg_error = 1'b0;
    endtask

    // Enter and leave at a falling edge; valid stays high for a back-to-back transfer.
    task automatic send_char(input logic [7:0] ch, input logic last, input logic [10:0] typed_res);
        int gap;
        int depth;
        gap = tx_quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_char <= ch;
        i_in_last <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        depth = pending_bytes.size();
        predict_decode(ch, last);
        if (typed_res[10]) begin
            while (pending_bytes.size() > depth) pending_bytes.delete(pending_bytes.size() - 1);
            queue_byte(typed_res[9:0]);
        end
        @(negedge i_clk);
    endtask

    // Hold the input until every byte is out, then let the pipeline settle.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(negedge i_clk);
        repeat (DRAIN_SLACK) @(negedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= mode;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        url_mode = mode;
    endtask

    task automatic send_message();
        int         len;
        int         pads;
        int         k;
        logic       wellformed;
        logic [7:0] ch;
        wellformed = $urandom_range(0, 9) < 7;
        len = wellformed ? 4 * $urandom_range(1, 3) : $urandom_range(1, 9);
        pads = $urandom_range(0, 2);
        for (k = 0; k < len; k++) begin
            ch = alphabet_char(6'($urandom_range(0, 63)));
            if (k >= len - pads) ch = CHAR_PAD;
            if ($urandom_range(0, 99) < (wellformed ? 3 : 15)) begin
                case ($urandom_range(0, 3))
                    0: ch = CHAR_MINUS;
                    1: ch = CHAR_UNDERSCORE;
                    2: ch = CHAR_PAD;
                    default: ch = 8'($urandom_range(0, 255));
                endcase
            end
            send_char(ch, k == len - 1, FROM_PREDICTOR);
            rand_items++;
        end
    endtask

    initial begin
        int r;
        int phase_start;
        dir_rows = '{
            {1'b0, "A",   1'b1, {1'b1, 8'h00, 1'b1, 1'b0}},
            {1'b0, "/",   1'b0, FROM_PREDICTOR},
            {1'b0, "+",   1'b0, FROM_PREDICTOR},
            {1'b0, "9",   1'b0, FROM_PREDICTOR},
            {1'b0, "z",   1'b1, FROM_PREDICTOR},
            {1'b0, "Q",   1'b0, FROM_PREDICTOR},
            {1'b0, "Q",   1'b0, FROM_PREDICTOR},
            {1'b0, "=",   1'b0, FROM_PREDICTOR},
            {1'b0, "=",   1'b1, {1'b1, 8'h41, 1'b1, 1'b0}},
            {1'b0, "=",   1'b0, FROM_PREDICTOR},
            {1'b0, "=",   1'b0, FROM_PREDICTOR},
            {1'b0, "=",   1'b0, FROM_PREDICTOR},
            {1'b0, "=",   1'b0, FROM_PREDICTOR},
            {1'b0, 8'hFF, 1'b1, ERROR_RESULT},
            {1'b0, "-",   1'b1, ERROR_RESULT},
            {1'b1, "-",   1'b0, FROM_PREDICTOR},
            {1'b1, "_",   1'b0, FROM_PREDICTOR},
            {1'b1, "=",   1'b1, FROM_PREDICTOR},
            {1'b1, "_",   1'b0, FROM_PREDICTOR},
            {1'b1, "0",   1'b0, FROM_PREDICTOR},
            {1'b1, "a",   1'b1, FROM_PREDICTOR},
            {1'b1, "A",   1'b0, FROM_PREDICTOR},
            {1'b1, 8'h00, 1'b0, FROM_PREDICTOR},
            {1'b1, "B",   1'b0, FROM_PREDICTOR},
            {1'b1, "D",   1'b1, ERROR_RESULT}
        };
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < DIR_ROWS; r++) begin
            if (r == 0 || dir_rows[r].mode != url_mode) begin
                drain_results();
                write_mode(dir_rows[r].mode);
            end
            send_char(dir_rows[r].ch, dir_rows[r].last, {dir_rows[r].typed, dir_rows[r].res});
        end

        while (rand_items < RAND_ITEMS) begin
            drain_results();
            write_mode(1'($urandom_range(0, 1)));
            tx_quiet = ($urandom_range(0, 3) == 0);
            phase_start = rand_items;
            while (rand_items - phase_start < PHASE_ITEMS) send_message();
        end

        drain_results();
        if (mismatch_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    // Output side: random stall per byte, one long hold-off to back the block up.
    initial begin
        t_byte_result want;
        int           gap;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_count % 16 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
            gap = (rx_count == HOLD_AT) ? HOLD_CYCLES : (rx_quiet ? 0 : $urandom_range(0, 10));
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            rx_count++;
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected transfer byte %h last %b error %b",
                         $time, o_out_byte, o_out_last, o_out_error);
                mismatch_count++;
            end else begin
                want = pending_bytes.pop_front();
                if (o_out_byte !== want.data) begin
                    $display("%0t: byte expected %h actual %h", $time, want.data, o_out_byte);
                    mismatch_count++;
                end
                if (o_out_last !== want.last) begin
                    $display("%0t: last expected %b actual %b", $time, want.last, o_out_last);
                    mismatch_count++;
                end
                if (o_out_error !== want.error) begin
                    $display("%0t: error expected %b actual %b", $time, want.error, o_out_error);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
